@@ rtl/core/ldsd_pkg.sv @@
// Shared types, constants and CRC helper for the loader signature detector.
`timescale 1ns / 1ps

package ldsd_pkg;

  localparam int SIG_ENTRIES_DEF     = 64;
  localparam int HANDLER_ENTRIES_DEF = 64;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [7:0]  RTS_BYTE = 8'h60;

  localparam logic [15:0] EXCL_ADDR_0 = 16'd119;
  localparam logic [15:0] EXCL_ADDR_1 = 16'h1C06;
  localparam logic [15:0] EXCL_ADDR_2 = 16'h1C07;
  localparam logic [15:0] EXCL_ADDR_3 = 16'h1802;

  localparam logic [15:0] MID_CRC_RST = 16'h38A2;
  localparam logic [4:0]  MID_VAR_RST = 5'd8;

  // register index, taken from byte address bit 2
  localparam logic REG_MID_CRC = 1'b0;
  localparam logic REG_MID_VAR = 1'b1;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_EXEC  = 2'd1,
    MODE_LDSIG = 2'd2,
    MODE_LDHND = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [5:0]  entry_index;
    logic [15:0] entry_key;
    logic [4:0]  entry_variant;
    logic [3:0]  entry_extra;
  } in_item_t;

  typedef struct packed {
    logic [4:0] variant;
    logic       matched;
    logic       handler_param;
    logic [3:0] link_mode;
  } out_item_t;

  typedef struct packed {
    logic [15:0] key;
    logic [4:0]  variant;
    logic [3:0]  link;
  } sig_entry_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [4:0]  variant;
    logic        param;
  } hnd_entry_t;

  typedef struct packed {
    logic [15:0] mid_crc;
    logic [4:0]  mid_var;
  } cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic is_excluded(input logic [15:0] a);
    return (a == EXCL_ADDR_0) || (a == EXCL_ADDR_1) ||
           (a == EXCL_ADDR_2) || (a == EXCL_ADDR_3);
  endfunction

endpackage

@@ rtl/core/ldsd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ldsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/ldsd_ctrl.sv @@
// Item sequencer: CRC update, table loads and first-match scans over both tables.
`timescale 1ns / 1ps

module ldsd_ctrl #(
  parameter int SIG_ENTRIES     = ldsd_pkg::SIG_ENTRIES_DEF,
  parameter int HANDLER_ENTRIES = ldsd_pkg::HANDLER_ENTRIES_DEF,
  localparam int SIG_AW = (SIG_ENTRIES > 1) ? $clog2(SIG_ENTRIES) : 1,
  localparam int HND_AW = (HANDLER_ENTRIES > 1) ? $clog2(HANDLER_ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ldsd_pkg::in_item_t   in_item,
  input  ldsd_pkg::cfg_t       cfg,
  output logic                 out_strobe,
  output ldsd_pkg::out_item_t  out_item,
  // signature table memory
  output logic                 sig_we,
  output logic [SIG_AW-1:0]    sig_waddr,
  output ldsd_pkg::sig_entry_t sig_wdata,
  output logic                 sig_re,
  output logic [SIG_AW-1:0]    sig_raddr,
  input  ldsd_pkg::sig_entry_t sig_rdata,
  // handler table memory
  output logic                 hnd_we,
  output logic [HND_AW-1:0]    hnd_waddr,
  output ldsd_pkg::hnd_entry_t hnd_wdata,
  output logic                 hnd_re,
  output logic [HND_AW-1:0]    hnd_raddr,
  input  ldsd_pkg::hnd_entry_t hnd_rdata
);

  localparam int SIG_CW = $clog2(SIG_ENTRIES + 1);
  localparam int HND_CW = $clog2(HANDLER_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIG,
    ST_HND
  } state_t;

  state_t                    state_r, state_nxt;
  logic [15:0]               crc_r, crc_nxt;
  logic [4:0]                det_r, det_nxt;
  logic [4:0]                prev_r, prev_nxt;
  logic [3:0]                link_r, link_nxt;
  logic [15:0]               addr_r, addr_nxt;
  logic [SIG_ENTRIES-1:0]    sig_valid_r, sig_valid_nxt;
  logic [HANDLER_ENTRIES-1:0] hnd_valid_r, hnd_valid_nxt;
  logic [SIG_CW-1:0]         scnt_r, scnt_nxt;
  logic [HND_CW-1:0]         hcnt_r, hcnt_nxt;
  logic                      pend_r, pend_nxt;
  logic                      vldq_r, vldq_nxt;
  logic                      out_strobe_r, out_strobe_nxt;
  ldsd_pkg::out_item_t       out_r, out_nxt;

  logic [SIG_AW+5:0]         sig_idx_ext;
  logic [HND_AW+5:0]         hnd_idx_ext;
  logic [15:0]               crc_upd;
  logic [4:0]                det_upd;
  logic [4:0]                ent_var;
  logic                      done;

  assign sig_idx_ext = (SIG_AW + 6)'(in_item.entry_index);
  assign hnd_idx_ext = (HND_AW + 6)'(in_item.entry_index);
  assign sig_waddr   = sig_idx_ext[SIG_AW-1:0];
  assign hnd_waddr   = hnd_idx_ext[HND_AW-1:0];
  assign sig_raddr   = scnt_r[SIG_AW-1:0];
  assign hnd_raddr   = hcnt_r[HND_AW-1:0];

  assign sig_wdata = '{key: in_item.entry_key, variant: in_item.entry_variant,
                       link: in_item.entry_extra};
  assign hnd_wdata = '{addr: in_item.entry_key, variant: in_item.entry_variant,
                       param: in_item.entry_extra[0]};

  assign crc_upd = ldsd_pkg::crc_byte(crc_r, in_item.data_byte);
  assign det_upd = ((cfg.mid_var != 5'd0) && (crc_upd == cfg.mid_crc) &&
                    (in_item.data_byte == ldsd_pkg::RTS_BYTE)) ? cfg.mid_var : det_r;

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  always_comb begin
    state_nxt      = state_r;
    crc_nxt        = crc_r;
    det_nxt        = det_r;
    prev_nxt       = prev_r;
    link_nxt       = link_r;
    addr_nxt       = addr_r;
    sig_valid_nxt  = sig_valid_r;
    hnd_valid_nxt  = hnd_valid_r;
    scnt_nxt       = scnt_r;
    hcnt_nxt       = hcnt_r;
    pend_nxt       = 1'b0;
    vldq_nxt       = vldq_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    sig_we         = 1'b0;
    hnd_we         = 1'b0;
    sig_re         = 1'b0;
    hnd_re         = 1'b0;
    ent_var        = 5'd0;
    done           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_item.mode)
            ldsd_pkg::MODE_WRITE: begin
              if (ldsd_pkg::is_excluded(in_item.address)) begin
                out_strobe_nxt = 1'b1;
                out_nxt = '{variant: det_r, matched: 1'b0, handler_param: 1'b0,
                            link_mode: link_r};
              end else begin
                prev_nxt = 5'd0;
                crc_nxt  = crc_upd;
                det_nxt  = det_upd;
                if (in_item.last_byte) begin
                  state_nxt = ST_SIG;
                  scnt_nxt  = '0;
                end else begin
                  out_strobe_nxt = 1'b1;
                  out_nxt = '{variant: det_upd, matched: 1'b0, handler_param: 1'b0,
                              link_mode: link_r};
                end
              end
            end
            ldsd_pkg::MODE_EXEC: begin
              // no detection this round: fall back to the previous one
              det_nxt   = (det_r == 5'd0) ? prev_r : det_r;
              addr_nxt  = in_item.address;
              state_nxt = ST_HND;
              hcnt_nxt  = '0;
            end
            ldsd_pkg::MODE_LDSIG: begin
              if (32'(in_item.entry_index) < SIG_ENTRIES) begin
                sig_we = 1'b1;
                sig_valid_nxt[sig_waddr] = 1'b1;
              end
              out_strobe_nxt = 1'b1;
              out_nxt = '{variant: 5'd0, matched: 1'b0, handler_param: 1'b0,
                          link_mode: link_r};
            end
            ldsd_pkg::MODE_LDHND: begin
              if (32'(in_item.entry_index) < HANDLER_ENTRIES) begin
                hnd_we = 1'b1;
                hnd_valid_nxt[hnd_waddr] = 1'b1;
              end
              out_strobe_nxt = 1'b1;
              out_nxt = '{variant: 5'd0, matched: 1'b0, handler_param: 1'b0,
                          link_mode: link_r};
            end
          endcase
        end
      end

      ST_SIG: begin
        // issue one read a cycle, check the entry read the cycle before
        if (scnt_r < SIG_CW'(SIG_ENTRIES)) begin
          sig_re   = 1'b1;
          pend_nxt = 1'b1;
          vldq_nxt = sig_valid_r[scnt_r[SIG_AW-1:0]];
          scnt_nxt = scnt_r + 1'b1;
        end
        if (pend_r) begin
          ent_var = vldq_r ? sig_rdata.variant : 5'd0;
          if (ent_var == 5'd0) begin
            done = 1'b1;
          end else if (sig_rdata.key == crc_r) begin
            det_nxt = ent_var;
            if (sig_rdata.link != 4'd0) begin
              link_nxt = sig_rdata.link;
            end
            done = 1'b1;
          end else if (scnt_r == SIG_CW'(SIG_ENTRIES)) begin
            done = 1'b1;
          end
        end
        if (done) begin
          state_nxt      = ST_IDLE;
          pend_nxt       = 1'b0;
          out_strobe_nxt = 1'b1;
          out_nxt = '{variant: det_nxt, matched: 1'b0, handler_param: 1'b0,
                      link_mode: link_nxt};
        end
      end

      ST_HND: begin
        if (hcnt_r < HND_CW'(HANDLER_ENTRIES)) begin
          hnd_re   = 1'b1;
          pend_nxt = 1'b1;
          vldq_nxt = hnd_valid_r[hcnt_r[HND_AW-1:0]];
          hcnt_nxt = hcnt_r + 1'b1;
        end
        out_nxt = '{variant: 5'd0, matched: 1'b0, handler_param: 1'b0, link_mode: link_r};
        if (pend_r) begin
          ent_var = vldq_r ? hnd_rdata.variant : 5'd0;
          if (ent_var == 5'd0) begin
            done = 1'b1;
          end else if ((ent_var == det_r) && (hnd_rdata.addr == addr_r)) begin
            out_nxt = '{variant: ent_var, matched: 1'b1, handler_param: hnd_rdata.param,
                        link_mode: link_r};
            done = 1'b1;
          end else if (hcnt_r == HND_CW'(HANDLER_ENTRIES)) begin
            done = 1'b1;
          end
        end
        if (done) begin
          // new round
          state_nxt      = ST_IDLE;
          pend_nxt       = 1'b0;
          out_strobe_nxt = 1'b1;
          crc_nxt        = ldsd_pkg::CRC_SEED;
          prev_nxt       = det_r;
          det_nxt        = 5'd0;
        end else begin
          out_nxt = out_r;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      crc_r        <= ldsd_pkg::CRC_SEED;
      det_r        <= 5'd0;
      prev_r       <= 5'd0;
      link_r       <= 4'd0;
      sig_valid_r  <= '0;
      hnd_valid_r  <= '0;
      scnt_r       <= '0;
      hcnt_r       <= '0;
      pend_r       <= 1'b0;
      vldq_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      crc_r        <= crc_nxt;
      det_r        <= det_nxt;
      prev_r       <= prev_nxt;
      link_r       <= link_nxt;
      sig_valid_r  <= sig_valid_nxt;
      hnd_valid_r  <= hnd_valid_nxt;
      scnt_r       <= scnt_nxt;
      hcnt_r       <= hcnt_nxt;
      pend_r       <= pend_nxt;
      vldq_r       <= vldq_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    addr_r <= addr_nxt;
    out_r  <= out_nxt;
  end

endmodule

@@ rtl/core/loader_signature_detector_core.sv @@
// Top level of the loader signature detector: config registers, sequencer, table memories.
`timescale 1ns / 1ps

// Loader signature detector. Items are offered on in_item with start and taken
// when busy is low; each item gives exactly one result on out_item, marked by
// out_strobe for one cycle, and the receiver cannot stall it. Write bytes that
// do not end a block, excluded-address writes and table loads need no scan:
// the result shows in the cycle after acceptance and busy stays low, so one
// such item can follow every cycle. A write byte with last_byte set to a
// non-excluded address scans the signature memory, an execute scans the
// handler memory; each memory has one read port with registered read data and
// the scan reads one entry a cycle, and the result shows in the cycle busy
// falls. After reset both tables are empty at once through per-entry valid
// flags; no clearing pass is run. Config registers sit at byte address 0
// (midstream_crc) and 4 (midstream_variant); the user must write them only
// while the block is idle, as the block itself does not enforce this.

module loader_signature_detector_core #(
  parameter int SIG_ENTRIES     = ldsd_pkg::SIG_ENTRIES_DEF,
  parameter int HANDLER_ENTRIES = ldsd_pkg::HANDLER_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // item input
  input  logic                start,
  output logic                busy,
  input  ldsd_pkg::in_item_t  in_item,
  // result output
  output logic                out_strobe,
  output ldsd_pkg::out_item_t out_item,
  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int SIG_AW = (SIG_ENTRIES > 1) ? $clog2(SIG_ENTRIES) : 1;
  localparam int HND_AW = (HANDLER_ENTRIES > 1) ? $clog2(HANDLER_ENTRIES) : 1;

  // config registers
  logic [15:0] mid_crc_r, mid_crc_nxt;
  logic [4:0]  mid_var_r, mid_var_nxt;
  logic        cfg_wr;
  ldsd_pkg::cfg_t cfg;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    mid_crc_nxt = mid_crc_r;
    mid_var_nxt = mid_var_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        ldsd_pkg::REG_MID_CRC: mid_crc_nxt = pwdata[15:0];
        ldsd_pkg::REG_MID_VAR: mid_var_nxt = pwdata[4:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_crc_r <= ldsd_pkg::MID_CRC_RST;
      mid_var_r <= ldsd_pkg::MID_VAR_RST;
    end else begin
      mid_crc_r <= mid_crc_nxt;
      mid_var_r <= mid_var_nxt;
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[2])
      ldsd_pkg::REG_MID_CRC: prdata = {16'd0, mid_crc_r};
      ldsd_pkg::REG_MID_VAR: prdata = {27'd0, mid_var_r};
    endcase
  end

  assign cfg = '{mid_crc: mid_crc_r, mid_var: mid_var_r};

  // table memories
  logic                 sig_we, sig_re;
  logic [SIG_AW-1:0]    sig_waddr, sig_raddr;
  ldsd_pkg::sig_entry_t sig_wdata, sig_rdata;
  logic                 hnd_we, hnd_re;
  logic [HND_AW-1:0]    hnd_waddr, hnd_raddr;
  ldsd_pkg::hnd_entry_t hnd_wdata, hnd_rdata;

  ldsd_ram #(
    .WIDTH ($bits(ldsd_pkg::sig_entry_t)),
    .DEPTH (SIG_ENTRIES)
  ) u_sig_ram (
    .clk   (clk),
    .we    (sig_we),
    .waddr (sig_waddr),
    .wdata (sig_wdata),
    .re    (sig_re),
    .raddr (sig_raddr),
    .rdata (sig_rdata)
  );

  ldsd_ram #(
    .WIDTH ($bits(ldsd_pkg::hnd_entry_t)),
    .DEPTH (HANDLER_ENTRIES)
  ) u_hnd_ram (
    .clk   (clk),
    .we    (hnd_we),
    .waddr (hnd_waddr),
    .wdata (hnd_wdata),
    .re    (hnd_re),
    .raddr (hnd_raddr),
    .rdata (hnd_rdata)
  );

  // sequencer: running CRC, detection state and table scans
  ldsd_ctrl #(
    .SIG_ENTRIES     (SIG_ENTRIES),
    .HANDLER_ENTRIES (HANDLER_ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .cfg        (cfg),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .sig_we     (sig_we),
    .sig_waddr  (sig_waddr),
    .sig_wdata  (sig_wdata),
    .sig_re     (sig_re),
    .sig_raddr  (sig_raddr),
    .sig_rdata  (sig_rdata),
    .hnd_we     (hnd_we),
    .hnd_waddr  (hnd_waddr),
    .hnd_wdata  (hnd_wdata),
    .hnd_re     (hnd_re),
    .hnd_raddr  (hnd_raddr),
    .hnd_rdata  (hnd_rdata)
  );

`ifndef SYNTHESIS
  // a scan holds its result until it ends, so no result shows while busy
  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result strobe while a scan is running");

  // every accepted item either gives its result next cycle or starts a scan
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe || busy))
    else $error("accepted item neither answered nor scanning");

  // a handler match always carries a nonzero variant
  a_match_has_variant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.matched) |-> (out_item.variant != 5'd0))
    else $error("handler match with variant zero");

  // the handler parameter is only given with a match
  a_param_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.matched) |-> !out_item.handler_param)
    else $error("handler parameter set without a match");
`endif

endmodule
